// File: rtl/hsd_pkg.sv
// ---------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the 2-D five-point heat stencil.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsd_pkg;

	// Widest grid row the line buffers hold
	localparam int MAX_WIDTH = 128;
	// Cells in one line buffer: a delay of up to MAX_WIDTH-1 points
	localparam int LINE_LEN  = MAX_WIDTH - 1;
	// Column counter width
	localparam int COL_W     = $clog2(MAX_WIDTH);
	// Register field widths
	localparam int WID_W     = 8;
	localparam int HGT_W     = 16;
	localparam int RX_W      = 24;
	localparam int DT_W      = 32;
	localparam int RCP_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	// Smallest grid edge
	localparam int MIN_DIM   = 3;
	// Reset values
	localparam int RCP_RESET = 65536;
	localparam int DIM_RESET = 128;

	// Signed Q16.16 sample
	typedef logic signed [31:0] word_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RX_COEFF    = 3'd0,
		CFG_RY_COEFF    = 3'd1,
		CFG_TIME_STEP   = 3'd2,
		CFG_DENOM_RECIP = 3'd3,
		CFG_GRID_WIDTH  = 3'd4,
		CFG_GRID_HEIGHT = 3'd5
	} cfg_idx_t;

	// Stencil operands of one interior point
	typedef struct packed {
		word_t u;   // center
		word_t w;   // west
		word_t e;   // east
		word_t n;   // north
		word_t s;   // south
		word_t f;   // source term
	} op_t;

	// Coefficients held in the configuration registers
	typedef struct packed {
		logic [RX_W-1:0]  rx;
		logic [RX_W-1:0]  ry;
		logic [DT_W-1:0]  dt;
		logic [RCP_W-1:0] recip;
	} coef_t;

endpackage

// File: rtl/hsd_cell.sv
// ---------------------------------------------------------------------------
// hsd_cell
// One storage cell of a line buffer: takes its left neighbor's word on each
// request, or the incoming word when it is the insertion point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsd_cell import hsd_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  logic  ins,
	input  word_t din,
	input  word_t prev_data,
	output word_t data
);

	word_t data_q;

	// shift or load
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= ins ? din : prev_data;
		end
	end

	assign data = data_q;

endmodule

// File: rtl/hsd_line.sv
// ---------------------------------------------------------------------------
// hsd_line
// Line buffer built as a chain of cells. Words enter at the cell picked by
// ins_sel and leave at the last cell, giving a delay set by the grid width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsd_line import hsd_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [LINE_LEN-1:0] ins_sel,
	input  word_t               din,
	output word_t               dout
);

	word_t cell_q [LINE_LEN];

	// chain of cells, each fed by its left neighbor
	for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
		word_t prev_w;
		if (i == 0) begin : g_head
			assign prev_w = din;
		end else begin : g_body
			assign prev_w = cell_q[i-1];
		end
		hsd_cell u_cell (
			.clk       (clk),
			.en        (en),
			.ins       (ins_sel[i]),
			.din       (din),
			.prev_data (prev_w),
			.data      (cell_q[i])
		);
	end

	assign dout = cell_q[LINE_LEN-1];

endmodule

// File: rtl/hsd_calc.sv
// ---------------------------------------------------------------------------
// hsd_calc
// Arithmetic pipeline of the stencil update: Laplacian terms, coefficient
// products, accumulation, reciprocal scaling, rounding and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsd_calc import hsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  item_valid,
	input  logic  item_last,
	input  op_t   item_op,
	input  coef_t coef,
	output logic  res_valid,
	output word_t res_value,
	output logic  res_last
);

	localparam logic signed [48:0] SAT_MAX = 49'sd2147483647;
	localparam logic signed [48:0] SAT_MIN = -49'sd2147483648;
	localparam logic signed [64:0] HALF    = 65'sd32768;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_q;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_q;

	op_t                op_s1;
	logic signed [34:0] dns_s2, dwe_s2;
	word_t              u_s2, f_s2, u_s3;
	logic signed [59:0] pns_s3, pwe_s3;
	logic signed [63:0] pf_s3;
	logic signed [60:0] a_s4;
	logic signed [49:0] b_s4;
	logic signed [45:0] q16_s5;
	logic signed [63:0] prod_s6;
	word_t              res_q;

	logic signed [48:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_q  <= v_s6;
		end
	end

	// rounding half up of the last product; the output register saturates it
	always_comb begin
		rnd = 49'((65'(prod_s6) + HALF) >>> 16);
	end

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// operands
			op_s1   <= item_op;
			last_s1 <= item_last;
			// second differences
			dns_s2  <= 35'(op_s1.n) - (35'(op_s1.u) <<< 1) + 35'(op_s1.s);
			dwe_s2  <= 35'(op_s1.w) - (35'(op_s1.u) <<< 1) + 35'(op_s1.e);
			u_s2    <= op_s1.u;
			f_s2    <= op_s1.f;
			last_s2 <= last_s1;
			// coefficient products
			pns_s3  <= 60'($signed({1'b0, coef.rx})) * 60'(dns_s2);
			pwe_s3  <= 60'($signed({1'b0, coef.ry})) * 60'(dwe_s2);
			pf_s3   <= 64'($signed({1'b0, coef.dt})) * 64'(f_s2);
			u_s3    <= u_s2;
			last_s3 <= last_s2;
			// partial sums
			a_s4    <= 61'(pns_s3) + 61'(pwe_s3);
			b_s4    <= (50'(u_s3) <<< 16) + 50'(pf_s3 >>> 16);
			last_s4 <= last_s3;
			// back to Q.16
			q16_s5  <= 46'((62'(a_s4) + 62'(b_s4)) >>> 16);
			last_s5 <= last_s4;
			// reciprocal scaling
			prod_s6 <= 64'(q16_s5) * 64'($signed({1'b0, coef.recip}));
			last_s6 <= last_s5;
			// output register
			if (rnd > SAT_MAX) begin
				res_q <= word_t'(SAT_MAX[31:0]);
			end else if (rnd < SAT_MIN) begin
				res_q <= word_t'(SAT_MIN[31:0]);
			end else begin
				res_q <= rnd[31:0];
			end
			last_q  <= last_s6;
		end
	end

	assign res_valid = v_q;
	assign res_value = res_q;
	assign res_last  = last_q;

endmodule

// File: rtl/heat_stencil_2d_step.sv
// ---------------------------------------------------------------------------
// heat_stencil_2d_step
// Five-point heat diffusion update over a grid streamed in raster order.
// Input channel (in_valid/in_stall): one grid point per request, old_value
// and source_value, row by row. Output channel (out_valid/out_stall): one
// request per interior point, new_value and grid_done on the last interior
// point of the grid; boundary points give no output.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while no point is in flight. Writing grid_width or grid_height
// restarts the raster at row 0, column 0.
// Throughput: one point per cycle while out_stall does not hold a result. A
// result leaves the 7-stage arithmetic pipeline after the point one row below
// it is taken; the first result of a grid needs two full rows plus two points.
// The row delays are chains of cells (up to 127 per buffer) shifted on each
// accepted point. When out_stall holds a result, the whole pipeline and
// in_stall hold. Reset clears counters, valid bits and configuration registers
// to their defaults; line buffer contents are refilled by each new grid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heat_stencil_2d_step import hsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input points
	input  logic                 in_valid,
	output logic                 in_stall,
	input  word_t                old_value,
	input  word_t                source_value,
	// results
	output logic                 out_valid,
	input  logic                 out_stall,
	output word_t                new_value,
	output logic                 grid_done,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// configuration registers
	logic [RX_W-1:0]  rx_coeff_q, ry_coeff_q;
	logic [DT_W-1:0]  time_step_q;
	logic [RCP_W-1:0] denom_recip_q;
	logic [WID_W-1:0] grid_width_q;
	logic [HGT_W-1:0] grid_height_q;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;

	logic             adv, accept, cfg_we, geom_we;
	logic [WID_W-1:0] w_eff, ins_pos;
	logic [HGT_W-1:0] h_eff;
	logic             interior, last_pt, row_end;
	logic [LINE_LEN-1:0] ins_sel;

	// window of the middle row
	word_t u_q, west_q, f_q;
	word_t east_w, east_f_w, north_w;

	op_t   op_w;
	coef_t coef_w;
	logic  res_valid, res_last;
	word_t res_value;

	// handshakes
	assign adv       = !(res_valid && out_stall);
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign geom_we   = cfg_we && (cfg_index inside {CFG_GRID_WIDTH, CFG_GRID_HEIGHT});

	// effective geometry
	always_comb begin
		if (grid_width_q < WID_W'(MIN_DIM)) begin
			w_eff = WID_W'(MIN_DIM);
		end else if (grid_width_q > WID_W'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = grid_width_q;
		end
		h_eff = (grid_height_q < HGT_W'(MIN_DIM)) ? HGT_W'(MIN_DIM) : grid_height_q;
	end

	// insertion point of the line buffers: delay of w-1 points
	always_comb begin
		ins_pos = WID_W'(MAX_WIDTH) - w_eff;
		for (int i = 0; i < LINE_LEN; i++) begin
			ins_sel[i] = (ins_pos == WID_W'(i));
		end
	end

	// point classification
	assign row_end  = (WID_W'(col_q) == w_eff - WID_W'(1));
	assign interior = (row_q >= HGT_W'(2)) && (col_q != '0) && (WID_W'(col_q) < w_eff - WID_W'(1));
	assign last_pt  = (row_q == h_eff - HGT_W'(1)) && (WID_W'(col_q) == w_eff - WID_W'(2));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_coeff_q    <= '0;
			ry_coeff_q    <= '0;
			time_step_q   <= '0;
			denom_recip_q <= RCP_W'(RCP_RESET);
			grid_width_q  <= WID_W'(DIM_RESET);
			grid_height_q <= HGT_W'(DIM_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RX_COEFF:    rx_coeff_q    <= cfg_data[RX_W-1:0];
				CFG_RY_COEFF:    ry_coeff_q    <= cfg_data[RX_W-1:0];
				CFG_TIME_STEP:   time_step_q   <= cfg_data[DT_W-1:0];
				CFG_DENOM_RECIP: denom_recip_q <= cfg_data[RCP_W-1:0];
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[WID_W-1:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_q == h_eff - HGT_W'(1)) ? '0 : row_q + HGT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// row delays: east (u and f) and north
	hsd_line u_line_east (
		.clk     (clk),
		.en      (accept),
		.ins_sel (ins_sel),
		.din     (old_value),
		.dout    (east_w)
	);

	hsd_line u_line_src (
		.clk     (clk),
		.en      (accept),
		.ins_sel (ins_sel),
		.din     (source_value),
		.dout    (east_f_w)
	);

	hsd_line u_line_north (
		.clk     (clk),
		.en      (accept),
		.ins_sel (ins_sel),
		.din     (west_q),
		.dout    (north_w)
	);

	// center and west cells of the window
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q    <= east_w;
			west_q <= u_q;
			f_q    <= east_f_w;
		end
	end

	assign op_w = '{u: u_q, w: west_q, e: east_w, n: north_w, s: old_value, f: f_q};
	assign coef_w = '{rx: rx_coeff_q, ry: ry_coeff_q, dt: time_step_q, recip: denom_recip_q};

	hsd_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (accept && interior),
		.item_last  (last_pt),
		.item_op    (op_w),
		.coef       (coef_w),
		.res_valid  (res_valid),
		.res_value  (res_value),
		.res_last   (res_last)
	);

	assign out_valid = res_valid;
	assign new_value = res_value;
	assign grid_done = res_last;

`ifndef SYNTHESIS
	// column stays inside the effective row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(col_q) < w_eff)
		else $error("column count outside grid row");

	// row stays inside the effective grid
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < h_eff)
		else $error("row count outside grid");

	// a geometry write restarts the raster
	a_geom_restart: assert property (@(posedge clk) disable iff (!arst_n)
		geom_we |=> (col_q == '0) && (row_q == '0))
		else $error("raster not restarted after geometry write");

	// a point taken while the output is held cannot happen
	a_no_take_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_stall) |-> !accept)
		else $error("point accepted while result held");
`endif

endmodule

// File: dv/heat_stencil_2d_step_test.sv
// ---------------------------------------------------------------------------
// heat_stencil_2d_step_test
// Self-checking bench for the five-point heat stencil. Grid points are
// streamed in raster order under random valid gaps and result stalls. A
// behavioral stencil with its own line buffers and registers predicts each
// interior update, and the results are compared in order. A short table of
// 3x3 grids with identity coefficients opens the run. Fixed setups then cover
// saturation, clamped geometry, a wide grid, a reciprocal above one, and a
// mid-grid restart. Random register settings and grids follow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heat_stencil_2d_step_test;
	import hsd_pkg::*;

	// Run shape
	localparam int ITEM_TARGET   = 1100;
	localparam int QUIET_AFTER   = 980;
	localparam int SETTLE_CYCLES = 24;
	localparam int STUCK_LIMIT   = 2000;
	localparam int REPORT_LIMIT  = 10;
	// Data flavors for generated points
	localparam int FLAVOR_WILD   = 0;
	localparam int FLAVOR_MILD   = 1;
	localparam int FLAVOR_EDGE   = 2;
	localparam int MILD_SPAN     = 100 * 65536;
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;
	// Saturation bounds of a Q16.16 result
	localparam longint TEMP_MAX  = 2147483647;
	localparam longint TEMP_MIN  = -longint'(2147483647) - 1;

	typedef struct packed {
		word_t temp;
		logic  last;
	} temp_result_t;

	typedef struct packed {
		word_t old_v;
		word_t src_v;
		logic  typed;
		word_t want;
		logic  want_last;
	} probe_row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	word_t                old_value    = '0;
	word_t                source_value = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	word_t                new_value;
	logic                 grid_done;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;

	heat_stencil_2d_step dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.old_value   (old_value),
		.source_value(source_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.new_value   (new_value),
		.grid_done   (grid_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Two 3x3 grids with identity coefficients: the single interior result
	// is the center point itself, with grid_done set.
	probe_row_t probe_rows [18] = '{
		'{32'h0001_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h0000_8000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h1234_5678, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'h0001_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
		'{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0}
	};

	// -----------------------------------------------------------------------
	// Stencil predictor: registers, line buffers, window and raster position
	// -----------------------------------------------------------------------
	logic [RX_W-1:0]  k_rx;
	logic [RX_W-1:0]  k_ry;
	logic [DT_W-1:0]  k_dt;
	logic [RCP_W-1:0] k_recip;
	logic [WID_W-1:0] k_width;
	logic [HGT_W-1:0] k_height;
	word_t            above_row  [MAX_WIDTH];
	word_t            center_row [MAX_WIDTH];
	word_t            center_src [MAX_WIDTH];
	word_t            west_tap;
	word_t            mid_tap;
	int               col_pos;
	int               row_pos;

	temp_result_t     awaited_temps [$];
	int               faults;
	int               points_sent;
	bit               in_chaos;
	bit               out_chaos;
	bit               moved;

	function automatic void clear_model();
		k_rx     = '0;
		k_ry     = '0;
		k_dt     = '0;
		k_recip  = RCP_W'(RCP_RESET);
		k_width  = WID_W'(DIM_RESET);
		k_height = HGT_W'(DIM_RESET);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			above_row[i]  = '0;
			center_row[i] = '0;
			center_src[i] = '0;
		end
		west_tap = '0;
		mid_tap  = '0;
		col_pos  = 0;
		row_pos  = 0;
	endfunction

	// Effective geometry: width clamped to [3, MAX_WIDTH], height floored at 3
	function automatic int span_cols();
		int w = k_width;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int span_rows();
		int h = k_height;
		if (h < MIN_DIM) h = MIN_DIM;
		return h;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		case (idx)
			CFG_RX_COEFF:    k_rx    = d[RX_W-1:0];
			CFG_RY_COEFF:    k_ry    = d[RX_W-1:0];
			CFG_TIME_STEP:   k_dt    = d[DT_W-1:0];
			CFG_DENOM_RECIP: k_recip = d[RCP_W-1:0];
			CFG_GRID_WIDTH: begin
				k_width = d[WID_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			CFG_GRID_HEIGHT: begin
				k_height = d[HGT_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			default: ;
		endcase
	endfunction

	// One point in; the update of the point one row above, if it is interior
	function automatic void stencil_take(input word_t ov, input word_t sv,
			output bit made, output temp_result_t got);
		int     cols;
		int     rows;
		int     c;
		int     r;
		longint u;
		longint acc;
		longint scaled;
		longint rounded;
		cols = span_cols();
		rows = span_rows();
		c    = col_pos;
		r    = row_pos;
		made = 1'b0;
		got  = '0;
		west_tap = mid_tap;
		mid_tap  = center_row[c];
		if (r >= 2 && c >= 1 && c + 1 < cols) begin
			u = mid_tap;
			acc = u * 65536;
			acc += longint'(k_rx) * (longint'(above_row[c]) - 2 * u + longint'(ov));
			acc += longint'(k_ry) * (longint'(west_tap) - 2 * u
				+ longint'(center_row[c + 1]));
			// source term: Q0.32 times Q16.16, floored back to Q.32
			acc += (longint'(k_dt) * longint'(center_src[c])) >>> 16;
			scaled  = (acc >>> 16) * longint'(k_recip);
			rounded = (scaled + 32768) >>> 16;
			if (rounded > TEMP_MAX) rounded = TEMP_MAX;
			if (rounded < TEMP_MIN) rounded = TEMP_MIN;
			got.temp = rounded[31:0];
			got.last = (r == rows - 1 && c == cols - 2);
			made = 1'b1;
		end
		// rotate the line buffers at this column
		above_row[c]  = center_row[c];
		center_row[c] = ov;
		center_src[c] = sv;
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= rows) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------
	function automatic word_t pick_word(int flavor);
		case (flavor)
			FLAVOR_MILD: return word_t'($urandom_range(0, 2 * MILD_SPAN) - MILD_SPAN);
			FLAVOR_EDGE: begin
				case ($urandom_range(0, 5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return '0;
					3: return '1;
					default: return word_t'($urandom);
				endcase
			end
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic logic [RX_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return RX_W'($urandom_range(0, 32'h8000));
			default: return RX_W'($urandom);
		endcase
	endfunction

	function automatic logic [DT_W-1:0] pick_dt();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return DT_W'($urandom_range(0, 32'h1000_0000));
			default: return DT_W'($urandom);
		endcase
	endfunction

	function automatic logic [RCP_W-1:0] pick_recip();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return RCP_W'(RCP_RESET);
			2: return '1;
			3, 4: return RCP_W'($urandom_range(20000, RCP_RESET));
			default: return RCP_W'($urandom);
		endcase
	endfunction

	// Occasionally set bits above the register field; they must be dropped
	function automatic logic [CFG_DAT_W-1:0] stray_bits(logic [CFG_DAT_W-1:0] field, int bits);
		if (bits < CFG_DAT_W && $urandom_range(0, 3) == 0)
			return field | ($urandom << bits);
		return field;
	endfunction

	function automatic void note_fault(string msg);
		faults++;
		if (faults <= REPORT_LIMIT) $display("mismatch: %s", msg);
	endfunction

	// Leaves cfg_valid high; the caller lowers it after its last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	// Leaves in_valid high so back-to-back points need no extra edge
	task automatic push_point(word_t ov, word_t sv, logic typed = 1'b0,
			word_t want = '0, logic want_last = 1'b0);
		bit           made;
		temp_result_t got;
		if (in_chaos && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		old_value    <= ov;
		source_value <= sv;
		do @(negedge clk); while (in_stall !== 1'b0);
		@(posedge clk);
		stencil_take(ov, sv, made, got);
		if (typed) begin
			got.temp = want;
			got.last = want_last;
		end
		if (typed || made)
			awaited_temps = {awaited_temps, got};
		points_sent++;
		if (points_sent >= QUIET_AFTER) begin
			in_chaos  = 1'b0;
			out_chaos = 1'b0;
		end
	endtask

	// Sender pause until all updates are back; settle covers points in flight
	// that give no result
	task automatic wait_for_results(bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_temps.size() != 0);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic feed_points(int count, int flavor);
		for (int i = 0; i < count; i++) begin
			push_point(pick_word(flavor), pick_word(flavor));
			if ($urandom_range(0, 149) == 0) wait_for_results(1'b0);
		end
	endtask

	task automatic pick_idling();
		in_chaos  = points_sent < QUIET_AFTER && $urandom_range(0, 3) != 0;
		out_chaos = points_sent < QUIET_AFTER && $urandom_range(0, 3) != 0;
	endtask

	// Random register subset, then whole grids (sometimes a broken one)
	task automatic random_phase();
		int count;
		if ($urandom_range(0, 1)) write_reg(CFG_RX_COEFF, stray_bits(pick_coef(), RX_W));
		if ($urandom_range(0, 1)) write_reg(CFG_RY_COEFF, stray_bits(pick_coef(), RX_W));
		if ($urandom_range(0, 1)) write_reg(CFG_TIME_STEP, pick_dt());
		if ($urandom_range(0, 1)) write_reg(CFG_DENOM_RECIP, stray_bits(pick_recip(), RCP_W));
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_GRID_WIDTH, stray_bits(($urandom_range(0, 7) == 0)
				? $urandom_range(0, 2) : $urandom_range(3, 14), WID_W));
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_GRID_HEIGHT, stray_bits(($urandom_range(0, 7) == 0)
				? $urandom_range(0, 2) : $urandom_range(3, 7), HGT_W));
		if ($urandom_range(0, 11) == 0) write_reg(CFG_UNMAPPED, $urandom);
		cfg_valid <= 1'b0;
		pick_idling();
		count = $urandom_range(1, 2) * span_cols() * span_rows();
		if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
		feed_points(count, $urandom_range(FLAVOR_WILD, FLAVOR_EDGE));
		wait_for_results(1'b1);
	endtask

	// -----------------------------------------------------------------------
	// Result side: stall bursts, in-order check, activity for the watchdog
	// -----------------------------------------------------------------------
	initial begin : out_idler
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else if (out_chaos && $urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 11);
			out_stall <= (hold > 0);
		end
	end

	always @(negedge clk) begin : result_check
		temp_result_t want;
		moved = arst_n && ((in_valid && in_stall === 1'b0)
			|| (out_valid === 1'b1 && !out_stall)
			|| (cfg_valid && cfg_ready === 1'b1));
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (awaited_temps.size() == 0) begin
				note_fault($sformatf("result %h done %b with none awaited",
					new_value, grid_done));
			end else begin
				want = awaited_temps.pop_front();
				if (new_value !== want.temp)
					note_fault($sformatf("new_value expected %h got %h",
						want.temp, new_value));
				if (grid_done !== want.last)
					note_fault($sformatf("grid_done expected %b got %b",
						want.last, grid_done));
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (moved) stuck = 0;
			else stuck++;
		end
		$display("FAILURE");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin : stimulus
		faults      = 0;
		points_sent = 0;
		in_chaos    = 1'b1;
		out_chaos   = 1'b1;
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity coefficients from reset, smallest grid
		write_reg(CFG_GRID_WIDTH, MIN_DIM);
		write_reg(CFG_GRID_HEIGHT, MIN_DIM);
		cfg_valid <= 1'b0;
		foreach (probe_rows[i])
			push_point(probe_rows[i].old_v, probe_rows[i].src_v, probe_rows[i].typed,
				probe_rows[i].want, probe_rows[i].want_last);
		wait_for_results(1'b1);

		// largest coefficients, reciprocal above one, clamped-up geometry, wrap
		write_reg(CFG_RX_COEFF, '1);
		write_reg(CFG_RY_COEFF, '1);
		write_reg(CFG_TIME_STEP, '1);
		write_reg(CFG_DENOM_RECIP, '1);
		write_reg(CFG_GRID_WIDTH, 0);
		write_reg(CFG_GRID_HEIGHT, 2);
		cfg_valid <= 1'b0;
		feed_points(2 * span_cols() * span_rows(), FLAVOR_EDGE);
		wait_for_results(1'b1);

		// zero reciprocal flattens everything
		write_reg(CFG_RX_COEFF, 0);
		write_reg(CFG_TIME_STEP, 0);
		write_reg(CFG_DENOM_RECIP, 0);
		write_reg(CFG_GRID_WIDTH, MIN_DIM);
		write_reg(CFG_GRID_HEIGHT, MIN_DIM);
		cfg_valid <= 1'b0;
		feed_points(span_cols() * span_rows(), FLAVOR_EDGE);
		wait_for_results(1'b1);

		// physical coefficients on the widest row (width register clamped down)
		write_reg(CFG_RX_COEFF, 32'h1999);
		write_reg(CFG_RY_COEFF, 32'h1999);
		write_reg(CFG_TIME_STEP, 32'h0CCC_CCCD);
		write_reg(CFG_DENOM_RECIP, 46811);
		write_reg(CFG_GRID_WIDTH, 200);
		write_reg(CFG_GRID_HEIGHT, MIN_DIM);
		cfg_valid <= 1'b0;
		pick_idling();
		feed_points(span_cols() * span_rows(), FLAVOR_MILD);
		wait_for_results(1'b1);

		// tallest grid, cut off mid-row by a geometry write
		write_reg(CFG_GRID_WIDTH, 5);
		write_reg(CFG_GRID_HEIGHT, 16'hFFFF);
		cfg_valid <= 1'b0;
		feed_points(22, FLAVOR_EDGE);
		wait_for_results(1'b1);
		write_reg(CFG_UNMAPPED, $urandom);
		write_reg(CFG_GRID_HEIGHT, 4);
		cfg_valid <= 1'b0;
		feed_points(2 * span_cols() * span_rows(), FLAVOR_WILD);
		wait_for_results(1'b1);

		while (points_sent < ITEM_TARGET) random_phase();

		wait_for_results(1'b1);
		if (faults == 0 && awaited_temps.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
